// ===== hdl/ecmd_pkg.sv =====
package ecmd_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CELL_SHIFT = 3'd0,
    REG_WINDOW     = 3'd1,
    REG_NEEDED     = 3'd2,
    REG_DEAD       = 3'd3,
    REG_NEIGHBOR   = 3'd4
  } reg_idx_t;

  localparam int XW = 10;
  localparam int YW = 9;
  localparam int CCOLW = 7;
  localparam int CROWW = 6;
  localparam int MaxCellShift = 6;

  typedef struct packed {
    logic [XW-1:0] pix_x;
    logic [YW-1:0] pix_y;
    logic [39:0]   stamp;
  } event_t;

  typedef struct packed {
    logic             detected;
    logic             filtered_out;
    logic [CCOLW-1:0] cell_col;
    logic [CROWW-1:0] cell_row;
  } result_t;

  typedef struct packed {
    logic [2:0]  cell_size_shift;
    logic [19:0] window_length;
    logic [15:0] events_needed;
    logic [23:0] dead_time;
    logic [19:0] neighbor_window;
  } cfg_t;

endpackage

// ===== hdl/ecmd_if.sv =====
interface ecmd_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ecmd_cfg.sv =====
module ecmd_cfg
  import ecmd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size_shift <= 3'd4;
      cfg.window_length   <= 20'd1000;
      cfg.events_needed   <= 16'd10;
      cfg.dead_time       <= 24'd50000;
      cfg.neighbor_window <= 20'd0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CELL_SHIFT: cfg.cell_size_shift <= cfg_data[2:0];
        REG_WINDOW:     cfg.window_length   <= cfg_data[19:0];
        REG_NEEDED:     cfg.events_needed   <= cfg_data[15:0];
        REG_DEAD:       cfg.dead_time       <= cfg_data[23:0];
        REG_NEIGHBOR:   cfg.neighbor_window <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/event_cell_motion_detector_core.sv =====
// result path: after the accepting edge the word passes S_RD0, S_RD1, S_RD2 and
//   S_CELL; the result is registered and held valid in S_OUT until it is taken
// sequence per word: accept, three row reads of the pixel memory
//   (above, below, own row) overlapped with the cell read, write-back, result
//   handshake; a held result blocks the input until it is taken
// reset: synchronous, active high; a clearing pass then zeroes the seen rows and the cell store
module event_cell_motion_detector_core
  import ecmd_pkg::*;
#(
  parameter int SENSOR_WIDTH   = 640,
  parameter int SENSOR_HEIGHT  = 480,
  parameter int MIN_CELL_SHIFT = 3,
  parameter int TIME_BITS      = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  ecmd_if.sink                in_ch,
  ecmd_if.source              out_ch
);

  localparam int CellStride = (SENSOR_WIDTH + (1 << MIN_CELL_SHIFT) - 1) >> MIN_CELL_SHIFT;
  localparam int CellRows = (SENSOR_HEIGHT + (1 << MIN_CELL_SHIFT) - 1) >> MIN_CELL_SHIFT;
  localparam int NumCells = CellStride * CellRows;
  localparam int RowW = $clog2(SENSOR_HEIGHT);
  localparam int CellW = $clog2(NumCells);
  localparam int ClrN = (SENSOR_HEIGHT > NumCells) ? SENSOR_HEIGHT : NumCells;
  localparam int ClrW = $clog2(ClrN + 1);
  localparam int TB = TIME_BITS;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD0   = 7'b0000100,
    S_RD1   = 7'b0001000,
    S_RD2   = 7'b0010000,
    S_CELL  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  cfg_t cfg;
  ecmd_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg);

  // pixel memories, one word per sensor row
  logic [SENSOR_WIDTH-1:0]    seen_mem [SENSOR_HEIGHT];
  logic [SENSOR_WIDTH*TB-1:0] time_mem [SENSOR_HEIGHT];
  // cell store
  logic [TB+TB+1+16-1:0]      cell_mem [NumCells];

  state_t state;
  logic [ClrW-1:0] clr;
  logic [XW-1:0] ex;
  logic [YW-1:0] ey;
  logic [TB-1:0] et;
  logic [1:0]    rsel;
  logic [1:0]    qsel;
  logic          q_ok;
  logic          corr;
  logic          corr_all;
  logic          in_frame;
  logic [2:0]    sh;
  logic [CellW-1:0] cidx;
  logic [SENSOR_WIDTH-1:0]    seen_q;
  logic [SENSOR_WIDTH*TB-1:0] time_q;
  logic [TB+TB+1+16-1:0]      cell_q;
  logic [RowW-1:0] rd_row;
  logic            rd_ok;
  logic [RowW-1:0] own_row;
  result_t res;
  logic    out_valid;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;
  assign own_row = ey[RowW-1:0];

  // row being fetched: rsel 0 above, 1 own, 2 below; a missing row reads the own row
  always_comb begin
    rd_row = own_row;
    rd_ok  = 1'b1;
    if (rsel == 2'd0) begin
      rd_ok = (ey != '0);
      if (rd_ok) rd_row = own_row - 1'b1;
    end else if (rsel == 2'd2) begin
      rd_ok = ({{(32-YW){1'b0}}, ey} < SENSOR_HEIGHT - 1);
      if (rd_ok) rd_row = own_row + 1'b1;
    end
  end

  // neighbor check over the row held in the read registers
  logic row_hit;
  always_comb begin
    logic [TB-1:0] tp;
    int xx;
    row_hit = 1'b0;
    for (int d = -1; d <= 1; d++) begin
      xx = int'(ex) + d;
      tp = '0;
      if (xx >= 0 && xx < SENSOR_WIDTH && !(d == 0 && qsel == 2'd1)) begin
        tp = time_q[xx*TB +: TB];
        if (seen_q[xx] && (et < tp || (et - tp) <= {{(TB-20){1'b0}}, cfg.neighbor_window}))
          row_hit = 1'b1;
      end
    end
  end

  // correlation so far, including the row now held and the filter-off bypass
  assign corr_all = corr | (q_ok & row_hit) | (cfg.neighbor_window == '0);

  // cell update
  logic [TB-1:0] c_ws, n_ws;
  logic [TB:0]   c_du, n_du;
  logic [15:0]   c_cnt, n_cnt, need;
  logic          det, cwr;
  always_comb begin
    logic [15:0] inc;
    {c_ws, c_du, c_cnt} = cell_q;
    need = (cfg.events_needed == '0) ? 16'd1 : cfg.events_needed;
    n_ws = c_ws; n_du = c_du; n_cnt = c_cnt; det = 1'b0; cwr = 1'b0;
    inc = c_cnt;
    if ({1'b0, et} >= c_du) begin
      cwr = 1'b1;
      if (c_cnt == '0 || (et > c_ws && (et - c_ws) > {{(TB-20){1'b0}}, cfg.window_length})) begin
        n_ws = et;
        inc = '0;
      end
      n_cnt = inc + 16'd1;
      if (n_cnt >= need) begin
        det = 1'b1;
        n_du = {1'b0, et} + {{(TB-23){1'b0}}, cfg.dead_time};
        n_cnt = '0;
        n_ws = et;
      end
    end
  end

  // memory reads, with the row tag of the fetched word
  always_ff @(posedge clk) begin
    seen_q <= seen_mem[rd_row];
    time_q <= time_mem[rd_row];
    cell_q <= cell_mem[cidx];
    qsel   <= rsel;
    q_ok   <= rd_ok;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (clr < SENSOR_HEIGHT) seen_mem[clr[RowW-1:0]] <= '0;
      if (clr < NumCells) cell_mem[clr[CellW-1:0]] <= '0;
    end else if (state == S_CELL && in_frame) begin
      seen_mem[own_row] <= seen_q | (SENSOR_WIDTH'(1) << ex);
      time_mem[own_row][ex*TB +: TB] <= et;
      if (corr_all && cwr) cell_mem[cidx] <= {n_ws, n_du, n_cnt};
    end
  end

  // sequencer; own row is fetched last so its write-back merges the fetched word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      rsel <= 2'd0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == ClrW'(ClrN - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          ex <= in_ch.data.pix_x;
          ey <= in_ch.data.pix_y;
          et <= TB'(in_ch.data.stamp);
          in_frame <= ({{(32-XW){1'b0}}, in_ch.data.pix_x} < SENSOR_WIDTH) &&
                      ({{(32-YW){1'b0}}, in_ch.data.pix_y} < SENSOR_HEIGHT);
          sh <= (cfg.cell_size_shift < 3'(MIN_CELL_SHIFT)) ? 3'(MIN_CELL_SHIFT) :
                (cfg.cell_size_shift > 3'(MaxCellShift)) ? 3'(MaxCellShift) :
                cfg.cell_size_shift;
          corr <= 1'b0;
          rsel <= 2'd0;
          state <= S_RD0;
        end
        S_RD0: begin
          rsel <= 2'd2;
          state <= S_RD1;
        end
        // row above held
        S_RD1: begin
          corr <= corr_all;
          rsel <= 2'd1;
          cidx <= CellW'((ey >> sh) * CellStride + (ex >> sh));
          state <= S_RD2;
        end
        // row below held
        S_RD2: begin
          corr <= corr_all;
          state <= S_CELL;
        end
        // own row and cell entry held
        S_CELL: begin
          res.cell_col <= in_frame ? CCOLW'(ex >> sh) : '0;
          res.cell_row <= in_frame ? CROWW'(ey >> sh) : '0;
          res.filtered_out <= in_frame && !corr_all;
          res.detected <= in_frame && corr_all && det;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_event_cell_motion_detector_core.sv =====
module tb_event_cell_motion_detector_core;
  import ecmd_pkg::*;

  localparam int SensorW = 640;
  localparam int SensorH = 480;
  localparam int MinShift = 3;
  localparam int CellStride = 80;
  localparam int NumCells = 4800;
  localparam int NumPixels = SensorW * SensorH;
  localparam int StallLimit = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ecmd_if #(.T(event_t)) in_ch ();
  ecmd_if #(.T(result_t)) out_ch ();

  event_cell_motion_detector_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the detector state
  bit          seen_map [NumPixels];
  bit [39:0]   fire_time [NumPixels];
  bit [39:0]   window_open [NumCells];
  bit [40:0]   quiet_until [NumCells];
  int unsigned hit_count [NumCells];
  bit [2:0]    shadow_shift;
  bit [19:0]   shadow_window;
  bit [15:0]   shadow_needed;
  bit [23:0]   shadow_dead;
  bit [19:0]   shadow_nbr;

  event_t  pending_events [$];
  result_t expected_results [$];
  bit [39:0] now_us;
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int detections = 0;
  int drops = 0;
  int idle_cycles = 0;

  // neighbor age test, a later stored time counts as fresh
  function automatic bit is_fresh(bit [39:0] t, bit [39:0] past);
    if (t < past) return 1'b1;
    return (t - past) <= shadow_nbr;
  endfunction

  // next result for one event, updating the shadow state
  function automatic result_t score_event(event_t ev);
    result_t r;
    int x;
    int y;
    int sh;
    int need;
    int ci;
    int cj;
    int k;
    int p;
    int q;
    bit corr;
    bit [39:0] t;
    r = '0;
    x = ev.pix_x;
    y = ev.pix_y;
    t = ev.stamp;
    if (x >= SensorW || y >= SensorH) return r;
    sh = shadow_shift;
    if (sh < MinShift) sh = MinShift;
    if (sh > MaxCellShift) sh = MaxCellShift;
    need = (shadow_needed == 0) ? 1 : shadow_needed;
    ci = x >> sh;
    cj = y >> sh;
    r.cell_col = ci[CCOLW-1:0];
    r.cell_row = cj[CROWW-1:0];
    p = y * SensorW + x;
    corr = 1'b1;
    if (shadow_nbr != 0) begin
      corr = 1'b0;
      for (int yy = y - 1; yy <= y + 1; yy++) begin
        for (int xx = x - 1; xx <= x + 1; xx++) begin
          if (yy < 0 || yy >= SensorH || xx < 0 || xx >= SensorW) continue;
          if (xx == x && yy == y) continue;
          q = yy * SensorW + xx;
          if (seen_map[q] && is_fresh(t, fire_time[q])) corr = 1'b1;
        end
      end
    end
    seen_map[p] = 1'b1;
    fire_time[p] = t;
    if (!corr) begin
      r.filtered_out = 1'b1;
      return r;
    end
    k = cj * CellStride + ci;
    if ({1'b0, t} < quiet_until[k]) return r;
    if (hit_count[k] == 0 || (t > window_open[k] && t - window_open[k] > shadow_window)) begin
      window_open[k] = t;
      hit_count[k] = 0;
    end
    hit_count[k]++;
    if (hit_count[k] < need) return r;
    quiet_until[k] = {1'b0, t} + shadow_dead;
    hit_count[k] = 0;
    window_open[k] = t;
    r.detected = 1'b1;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(score_event(in_ch.data));
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_events.size() > 0 &&
            ((words_sent > 700 && words_sent < 950) || $urandom_range(99) >= 35)) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_events.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, with one long hold-off to back the block up
  int hold_left;
  int rx_count;
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      rx_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rx_count <= rx_count + 1;
        words_checked++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none, actual %h", $time, out_ch.data);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.detected) detections++;
          if (exp_r.filtered_out) drops++;
          if (out_ch.data.detected !== exp_r.detected) begin
            errors++;
            $display("%0t detected: expected %b, actual %b", $time,
                     exp_r.detected, out_ch.data.detected);
          end
          if (out_ch.data.filtered_out !== exp_r.filtered_out) begin
            errors++;
            $display("%0t filtered_out: expected %b, actual %b", $time,
                     exp_r.filtered_out, out_ch.data.filtered_out);
          end
          if (out_ch.data.cell_col !== exp_r.cell_col) begin
            errors++;
            $display("%0t cell_col: expected %0d, actual %0d", $time,
                     exp_r.cell_col, out_ch.data.cell_col);
          end
          if (out_ch.data.cell_row !== exp_r.cell_row) begin
            errors++;
            $display("%0t cell_row: expected %0d, actual %0d", $time,
                     exp_r.cell_row, out_ch.data.cell_row);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_count == 400 && out_ch.valid && out_ch.ready) begin
        hold_left <= 300;
        out_ch.ready <= 1'b0;
      end else if (rx_count > 700 && rx_count < 950) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_event(int x, int y, bit [39:0] t);
    event_t ev;
    ev.pix_x = x[XW-1:0];
    ev.pix_y = y[YW-1:0];
    ev.stamp = t;
    pending_events.push_back(ev);
  endtask

  // clustered burst around one pixel, the kind of traffic that detects
  task automatic add_burst();
    int cx;
    int cy;
    int n;
    cx = $urandom_range(638, 1);
    cy = $urandom_range(478, 1);
    n = $urandom_range(12, 3);
    repeat (n) begin
      now_us += $urandom_range(20, 0);
      add_event(cx + $urandom_range(2, 0) - 1, cy + $urandom_range(2, 0) - 1, now_us);
    end
  endtask

  // isolated noise, off-sensor words and the odd stamp from the past
  task automatic add_noise();
    int sel;
    sel = $urandom_range(9);
    now_us += $urandom_range(500, 0);
    if (sel == 0)
      add_event($urandom_range(1023), $urandom_range(511), now_us);
    else if (sel == 1)
      add_event($urandom_range(639), $urandom_range(479), now_us - $urandom_range(100, 1));
    else
      add_event($urandom_range(639), $urandom_range(479), now_us);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_events.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(bit [2:0] sh, bit [19:0] win, bit [15:0] need,
                               bit [23:0] dead, bit [19:0] nbr);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_CELL_SHIFT; cfg_data <= CfgDataW'(sh);
    @(posedge clk);
    cfg_index <= REG_WINDOW; cfg_data <= CfgDataW'(win);
    @(posedge clk);
    cfg_index <= REG_NEEDED; cfg_data <= CfgDataW'(need);
    @(posedge clk);
    cfg_index <= REG_DEAD; cfg_data <= dead;
    @(posedge clk);
    cfg_index <= REG_NEIGHBOR; cfg_data <= CfgDataW'(nbr);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_shift = sh;
    shadow_window = win;
    shadow_needed = need;
    shadow_dead = dead;
    shadow_nbr = nbr;
  endtask

  task automatic random_traffic(int n_words);
    while (n_words > 0) begin
      if ($urandom_range(99) < 70) add_burst();
      else add_noise();
      n_words = n_words - 1;
    end
  endtask

  // stimulus and phase sequencing
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    now_us = 40'd100;
    shadow_shift = 3'd4;
    shadow_window = 20'd1000;
    shadow_needed = 16'd10;
    shadow_dead = 24'd50000;
    shadow_nbr = 20'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset
    random_traffic(8);
    wait_drained();

    // directed: corners, off-sensor, neighbor filter, clamped shift, max stamp
    load_settings(3'd0, 20'd1000, 16'd2, 24'd0, 20'd5);
    add_event(0, 0, 40'd1000);
    add_event(1, 1, 40'd1002);
    add_event(0, 1, 40'd1003);
    add_event(639, 479, 40'd1004);
    add_event(638, 478, 40'd1020);
    add_event(639, 0, 40'd1021);
    add_event(0, 479, 40'd1022);
    add_event(1023, 511, 40'd1023);
    add_event(640, 0, 40'd1024);
    add_event(0, 480, 40'd1025);
    add_event(1, 0, 40'd900);
    add_event(2, 2, 40'd1100);
    add_event(300, 200, 40'hFF_FFFF_FFF0);
    add_event(301, 201, 40'hFF_FFFF_FFFF);
    add_event(300, 201, 40'hFF_FFFF_FFFF);
    add_event(512, 256, 40'd2000);
    add_event(511, 255, 40'd2001);
    wait_drained();

    now_us = 40'd5000;
    load_settings(3'd4, 20'd1000, 16'd10, 24'd50000, 20'd0);
    random_traffic(40);
    wait_drained();
    load_settings(3'd7, 20'd0, 16'd0, 24'd0, 20'd0);
    random_traffic(38);
    wait_drained();
    load_settings(3'd3, 20'd1000000, 16'd3, 24'hFFFFFF, 20'd1000000);
    random_traffic(40);
    wait_drained();
    now_us = {8'($urandom_range(255)), $urandom()};
    load_settings(3'd6, 20'hFFFFF, 16'hFFFF, 24'd100, 20'hFFFFF);
    random_traffic(38);
    wait_drained();
    load_settings(3'd5, 20'd200, 16'd4, 24'd300, 20'd1);
    random_traffic(40);
    wait_drained();
    now_us = 40'hFF_FFFF_0000;
    load_settings(3'd3, 20'd50, 16'd1, 24'd10, 20'd0);
    random_traffic(36);
    wait_drained();
    load_settings(3'd6, 20'd5000, 16'd5, 24'd2000, 20'd200);
    random_traffic(40);
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t %0d expected words never arrived", $time, expected_results.size());
    end
    $display("covered %0d events over 9 register settings: %0d checked, %0d detections,",
             words_sent, words_checked, detections);
    $display("%0d dropped by the neighbor filter, %0d mismatches", drops, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
